>>> rtl/core/hvn_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal package
// Shared constants, configuration and job types for the vertex stream.
// ----------------------------------------------------------------------------
package hvn_pkg;

   // Default grid row capacity and widest column code a job can carry.
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int COL_W         = 13;

   // Depth of the job queue between front and back (a power of two).
   localparam int QUEUE_DEPTH   = 4;

   // Normal arithmetic.
   localparam int NORM_BITS     = 15;
   localparam int SUM_W         = 34;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_GRID_WIDTH     = 2'd0,
      CSR_GRID_HEIGHT    = 2'd1,
      CSR_VERTEX_SPACING = 2'd2
   } csr_index_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [10:0] grid_width;
      logic [12:0] grid_height;
      logic [15:0] vertex_spacing;
   } csr_type;

   // One classified sample, handed from front to back.
   typedef struct packed {
      logic [COL_W-1:0]    col;
      logic [11:0]         row;
      logic signed [15:0]  self_h;
      logic signed [15:0]  cur_h;
      logic signed [16:0]  dx;
      logic signed [16:0]  dz;
      logic                interior;
      logic                emit_above;
      logic                emit_cur;
      logic                is_last;
   } job_type;

endpackage

>>> rtl/core/heightmap_vertex_normal_stream.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal stream
// Turns raster-order height samples into terrain vertices with unit normals.
// ----------------------------------------------------------------------------
// Usage:
//   Height samples enter on the req_ queue port (push while full is low) in
//   raster order. Vertices leave on the rsp_ queue port, oldest first, and a
//   transfer happens when pop is high and empty is low. The csr_ port writes
//   grid_width, grid_height and vertex_spacing and is always ready. The user
//   writes it only while the block is idle; the block does not enforce this.
//   The front end steps through accept, row buffer read and row buffer
//   write for each sample before it takes the next one. A sample of the
//   first row emits nothing, a middle-row sample emits the vertex one row
//   above, a last-row sample emits that vertex and then its own. An
//   interior vertex in the back end waits on the 15-step bit-serial normal
//   units, border vertices do not. A four-entry job queue decouples the two.
//   After reset the row buffers are cleared, one entry per cycle, through all
//   MAX_WIDTH entries, and full stays high meanwhile. When the receiver stops
//   popping, the result register holds, the job queue fills and then full
//   rises until results drain.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_stream import hvn_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [15:0] req_height,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [9:0]         rsp_col,
   output logic [11:0]        rsp_row,
   output logic [25:0]        rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [27:0]        rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   csr_type cfg_ff;
   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_empty;
   job_type q_job_in;
   job_type q_job_out;

   assign csr_ready = 1'b1;

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width     <= 11'd2;
         cfg_ff.grid_height    <= 13'd2;
         cfg_ff.vertex_spacing <= 16'd256;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:     cfg_ff.grid_width     <= csr_wdata[10:0];
            CSR_GRID_HEIGHT:    cfg_ff.grid_height    <= csr_wdata[12:0];
            CSR_VERTEX_SPACING: cfg_ff.vertex_spacing <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   hvn_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_height (req_height),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_job_in)
   );

   hvn_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .job_in  (q_job_in),
      .full    (q_full),
      .pop     (q_pop),
      .job_out (q_job_out),
      .empty   (q_empty)
   );

   hvn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_job      (q_job_out),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row),
      .rsp_pos_x  (rsp_pos_x),
      .rsp_pos_y  (rsp_pos_y),
      .rsp_pos_z  (rsp_pos_z),
      .rsp_norm_x (rsp_norm_x),
      .rsp_norm_y (rsp_norm_y),
      .rsp_norm_z (rsp_norm_z),
      .rsp_last   (rsp_last)
   );

`ifndef SYNTHESIS
   // The final vertex of a grid lies on the border and points straight up.
   a_last_is_border: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |->
         (rsp_norm_y == ONE_Q14 && rsp_norm_x == 16'sd0 && rsp_norm_z == 16'sd0))
      else $error("last vertex carries a non-border normal");

   // No sample is taken right after reset, while the row buffers clear.
   a_full_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_full)
      else $error("input not held off during row buffer clear");

   // Nothing is shown on the result port in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("result shown right after reset");
`endif

endmodule

>>> rtl/core/hvn_front.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal front end
// Tracks the grid position, keeps the two row buffers and classifies samples.
// ----------------------------------------------------------------------------
module hvn_front import hvn_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  csr_type            cfg,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [15:0] req_height,
   input  logic               q_full,
   output logic               q_push,
   output job_type            q_job
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > 11) ? WW : 11;
   localparam logic [CW-1:0] W_MAX = CW'(MAX_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

   typedef enum logic [1:0] {
      F_CLEAR,
      F_IDLE,
      F_READ,
      F_WRITE
   } state_type;

   state_type          state_ff;
   logic [AW-1:0]      clear_addr_ff;
   logic [AW-1:0]      in_col_ff;
   logic [11:0]        in_row_ff;
   logic [AW-1:0]      c_ff;
   logic [11:0]        r_ff;
   logic signed [15:0] cur_ff;

   logic [15:0]        row_above_mem [MAX_WIDTH];
   logic [15:0]        row_two_mem   [MAX_WIDTH];
   logic [15:0]        ra_self_ff;
   logic [15:0]        ra_right_ff;
   logic [15:0]        rt_left_ff;
   logic [15:0]        rt_up_ff;

   logic [CW-1:0]      w_ext;
   logic [CW-1:0]      w_clamp;
   logic [AW-1:0]      w_last;
   logic [12:0]        h_clamp;
   logic [11:0]        h_last;
   logic [AW-1:0]      c_now;
   logic [11:0]        r_now;
   logic               accept;

   // Clamp the configured grid size and the current position to it.
   always_comb begin
      w_ext = CW'(cfg.grid_width);
      if (w_ext < CW'(2)) begin
         w_clamp = CW'(2);
      end else if (w_ext > W_MAX) begin
         w_clamp = W_MAX;
      end else begin
         w_clamp = w_ext;
      end
      w_last = AW'(w_clamp - CW'(1));
      if (cfg.grid_height < 13'd2) begin
         h_clamp = 13'd2;
      end else if (cfg.grid_height > 13'd4096) begin
         h_clamp = 13'd4096;
      end else begin
         h_clamp = cfg.grid_height;
      end
      h_last = 12'(h_clamp - 13'd1);
      c_now  = (in_col_ff > w_last) ? w_last : in_col_ff;
      r_now  = (in_row_ff > h_last) ? h_last : in_row_ff;
   end

   assign req_full = (state_ff != F_IDLE) || q_full;
   assign accept   = req_push && !req_full;

   // Sequencer: clearing pass, then accept, read, write per sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_CLEAR;
         clear_addr_ff <= '0;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
      end else begin
         unique case (state_ff)
            F_CLEAR: begin
               clear_addr_ff <= clear_addr_ff + AW'(1);
               if (clear_addr_ff == LAST_ADDR) begin
                  state_ff <= F_IDLE;
               end
            end
            F_IDLE: begin
               if (accept) begin
                  c_ff   <= c_now;
                  r_ff   <= r_now;
                  cur_ff <= req_height;
                  if (c_now == w_last) begin
                     in_col_ff <= '0;
                     in_row_ff <= (r_now == h_last) ? 12'd0 : r_now + 12'd1;
                  end else begin
                     in_col_ff <= c_now + AW'(1);
                     in_row_ff <= r_now;
                  end
                  state_ff <= F_READ;
               end
            end
            F_READ: begin
               state_ff <= F_WRITE;
            end
            F_WRITE: begin
               state_ff <= F_IDLE;
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

   // Row buffers: two read ports each, one write port each.
   always_ff @(posedge clock) begin
      ra_self_ff  <= row_above_mem[c_ff];
      ra_right_ff <= row_above_mem[c_ff + AW'(1)];
      rt_left_ff  <= row_two_mem[c_ff - AW'(1)];
      rt_up_ff    <= row_two_mem[c_ff];
      if (state_ff == F_CLEAR) begin
         row_above_mem[clear_addr_ff] <= '0;
         row_two_mem[clear_addr_ff]   <= '0;
      end else if (state_ff == F_WRITE) begin
         row_two_mem[c_ff]   <= ra_self_ff;
         row_above_mem[c_ff] <= cur_ff;
      end
   end

   // Classify the sample and build its job.
   always_comb begin
      q_job.col        = COL_W'(c_ff);
      q_job.row        = r_ff;
      q_job.self_h     = ra_self_ff;
      q_job.cur_h      = cur_ff;
      q_job.dx         = $signed({rt_left_ff[15], rt_left_ff})
                       - $signed({ra_right_ff[15], ra_right_ff});
      q_job.dz         = $signed({cur_ff[15], cur_ff})
                       - $signed({rt_up_ff[15], rt_up_ff});
      q_job.interior   = (c_ff != '0) && (c_ff < w_last) && (r_ff > 12'd1);
      q_job.emit_above = (r_ff != 12'd0);
      q_job.emit_cur   = (r_ff == h_last);
      q_job.is_last    = (c_ff == w_last);
      q_push           = (state_ff == F_WRITE) && (q_job.emit_above || q_job.emit_cur);
   end

endmodule

>>> rtl/core/hvn_queue.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal job queue
// Short FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
module hvn_queue import hvn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type job_in,
   output logic    full,
   input  logic    pop,
   output job_type job_out,
   output logic    empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW:0]   count_ff;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign job_out = slot_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (PW+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (PW+1)'(1);
         end
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

>>> rtl/core/hvn_norm.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal component unit
// Finds round(mag * 16384 / sqrt(s)) one result bit per cycle.
// ----------------------------------------------------------------------------
module hvn_norm import hvn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [16:0]          mag,
   input  logic [SUM_W-1:0]     sum,
   output logic                 done,
   output logic [NORM_BITS-1:0] result
);

   localparam int PW = 68;

   typedef enum logic [1:0] {
      N_IDLE,
      N_SQUARE,
      N_ITER
   } state_type;

   state_type              state_ff;
   logic                   done_ff;
   logic [16:0]            mag_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic signed [PW-1:0]   x_ff;
   logic signed [PW-1:0]   p_ff;
   logic signed [PW-1:0]   q_ff;
   logic [NORM_BITS-1:0]   m_ff;
   logic [3:0]             k_ff;

   logic signed [PW-1:0]   s_ext;
   logic [4:0]             sh_q;
   logic [4:0]             sh_s;
   logic signed [PW-1:0]   p_trial;

   // Trial for result bit k: t grows by 2^(k+1), so t*t*s grows by
   // (t*s) << (k+2) plus s << (2k+2).
   always_comb begin
      s_ext   = PW'(sum_ff);
      sh_q    = 5'(k_ff) + 5'd2;
      sh_s    = {k_ff, 1'b0} + 5'd2;
      p_trial = p_ff + (q_ff <<< sh_q) + (s_ext <<< sh_s);
   end

   // Iteration sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  mag_ff   <= mag;
                  sum_ff   <= sum;
                  state_ff <= N_SQUARE;
               end
            end
            N_SQUARE: begin
               x_ff     <= PW'(mag_ff * mag_ff) <<< 30;
               p_ff     <= s_ext;
               q_ff     <= -s_ext;
               m_ff     <= '0;
               k_ff     <= 4'(NORM_BITS - 1);
               state_ff <= N_ITER;
            end
            N_ITER: begin
               if (p_trial <= x_ff) begin
                  p_ff       <= p_trial;
                  q_ff       <= q_ff + (s_ext <<< (5'(k_ff) + 5'd1));
                  m_ff[k_ff] <= 1'b1;
               end
               if (k_ff == 4'd0) begin
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else begin
                  k_ff <= k_ff - 4'd1;
               end
            end
            default: begin
               state_ff <= N_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = m_ff;

endmodule

>>> rtl/core/hvn_back.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal back end
// Computes positions and normals for each job and emits up to two vertices.
// ----------------------------------------------------------------------------
module hvn_back import hvn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  csr_type            cfg,
   input  logic               q_empty,
   output logic               q_pop,
   input  job_type            q_job,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [9:0]         rsp_col,
   output logic [11:0]        rsp_row,
   output logic [25:0]        rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [27:0]        rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic               rsp_last
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_PREP,
      B_NORM,
      B_EMIT_A,
      B_EMIT_B
   } state_type;

   state_type            state_ff;
   job_type              job_ff;
   logic [32:0]          dx2_ff;
   logic [32:0]          dz2_ff;
   logic [25:0]          pos_x_ff;
   logic [27:0]          pos_za_ff;
   logic [27:0]          pos_zb_ff;
   logic                 start_ff;

   logic                 rsp_valid_ff;
   logic [9:0]           rsp_col_ff;
   logic [11:0]          rsp_row_ff;
   logic [25:0]          rsp_pos_x_ff;
   logic signed [15:0]   rsp_pos_y_ff;
   logic [27:0]          rsp_pos_z_ff;
   logic signed [15:0]   rsp_norm_x_ff;
   logic signed [15:0]   rsp_norm_y_ff;
   logic signed [15:0]   rsp_norm_z_ff;
   logic                 rsp_last_ff;

   logic [SUM_W-1:0]     sum;
   logic [16:0]          mag_x;
   logic [16:0]          mag_z;
   logic [2:0]           lane_done;
   logic [NORM_BITS-1:0] m_x;
   logic [NORM_BITS-1:0] m_y;
   logic [NORM_BITS-1:0] m_z;
   logic signed [15:0]   nx;
   logic signed [15:0]   ny;
   logic signed [15:0]   nz;
   logic                 out_free;

   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign out_free = !rsp_valid_ff || rsp_pop;

   // Squared length and component magnitudes for the normal lanes.
   always_comb begin
      sum   = SUM_W'(dx2_ff) + SUM_W'(dz2_ff) + SUM_W'(262144);
      mag_x = job_ff.dx[16] ? 17'(-job_ff.dx) : 17'(job_ff.dx);
      mag_z = job_ff.dz[16] ? 17'(-job_ff.dz) : 17'(job_ff.dz);
   end

   hvn_norm u_norm_x (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .mag    (mag_x),
      .sum    (sum),
      .done   (lane_done[0]),
      .result (m_x)
   );

   hvn_norm u_norm_y (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .mag    (17'd512),
      .sum    (sum),
      .done   (lane_done[1]),
      .result (m_y)
   );

   hvn_norm u_norm_z (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .mag    (mag_z),
      .sum    (sum),
      .done   (lane_done[2]),
      .result (m_z)
   );

   // Signed normal of the upper vertex; borders point straight up.
   always_comb begin
      if (job_ff.interior) begin
         nx = job_ff.dx[16] ? -16'(m_x) : 16'(m_x);
         ny = 16'(m_y);
         nz = job_ff.dz[16] ? -16'(m_z) : 16'(m_z);
      end else begin
         nx = '0;
         ny = ONE_Q14;
         nz = '0;
      end
   end

   // Job sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  job_ff   <= q_job;
                  state_ff <= B_PREP;
               end
            end
            B_PREP: begin
               dx2_ff    <= 33'(job_ff.dx * job_ff.dx);
               dz2_ff    <= 33'(job_ff.dz * job_ff.dz);
               pos_x_ff  <= 26'(job_ff.col * cfg.vertex_spacing);
               pos_za_ff <= 28'((job_ff.row - 12'd1) * cfg.vertex_spacing);
               pos_zb_ff <= 28'(job_ff.row * cfg.vertex_spacing);
               if (!job_ff.emit_above) begin
                  state_ff <= B_EMIT_B;
               end else if (job_ff.interior) begin
                  start_ff <= 1'b1;
                  state_ff <= B_NORM;
               end else begin
                  state_ff <= B_EMIT_A;
               end
            end
            B_NORM: begin
               if (&lane_done) begin
                  state_ff <= B_EMIT_A;
               end
            end
            B_EMIT_A: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_col_ff    <= job_ff.col[9:0];
                  rsp_row_ff    <= job_ff.row - 12'd1;
                  rsp_pos_x_ff  <= pos_x_ff;
                  rsp_pos_y_ff  <= job_ff.self_h;
                  rsp_pos_z_ff  <= pos_za_ff;
                  rsp_norm_x_ff <= nx;
                  rsp_norm_y_ff <= ny;
                  rsp_norm_z_ff <= nz;
                  rsp_last_ff   <= 1'b0;
                  state_ff      <= job_ff.emit_cur ? B_EMIT_B : B_IDLE;
               end
            end
            B_EMIT_B: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_col_ff    <= job_ff.col[9:0];
                  rsp_row_ff    <= job_ff.row;
                  rsp_pos_x_ff  <= pos_x_ff;
                  rsp_pos_y_ff  <= job_ff.cur_h;
                  rsp_pos_z_ff  <= pos_zb_ff;
                  rsp_norm_x_ff <= '0;
                  rsp_norm_y_ff <= ONE_Q14;
                  rsp_norm_z_ff <= '0;
                  rsp_last_ff   <= job_ff.is_last;
                  state_ff      <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_pos_x  = rsp_pos_x_ff;
   assign rsp_pos_y  = rsp_pos_y_ff;
   assign rsp_pos_z  = rsp_pos_z_ff;
   assign rsp_norm_x = rsp_norm_x_ff;
   assign rsp_norm_y = rsp_norm_y_ff;
   assign rsp_norm_z = rsp_norm_z_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
